FILE: hw/rtl/rar_pkg.sv
// rar_pkg: shared types and constants for rational_arith_reduce.
// No dependencies.
`default_nettype none
package rar_pkg;
  localparam int DataWidthDef = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_DIV = 2'd2,
    OP_EQ  = 2'd3
  } op_t;
endpackage
`default_nettype wire

FILE: hw/rtl/rar_front.sv
// rar_front: accepts items, forms the cross products and the overflow flag.
// Depends on rar_pkg. Products are formed one per cycle on a shared multiplier.
`default_nettype none
module rar_front import rar_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_op,
  input  wire logic [DATA_WIDTH-1:0]   in_an,
  input  wire logic [DATA_WIDTH-1:0]   in_ad,
  input  wire logic [DATA_WIDTH-1:0]   in_bn,
  input  wire logic [DATA_WIDTH-1:0]   in_bd,
  output logic                         q_valid,
  input  wire logic                    q_ready,
  // queue item: op, two fractions to reduce (eq uses both, others first), ovf
  output logic [1:0]                   q_op,
  output logic [DATA_WIDTH-1:0]        q_n1,
  output logic [DATA_WIDTH-1:0]        q_d1,
  output logic [DATA_WIDTH-1:0]        q_n2,
  output logic [DATA_WIDTH-1:0]        q_d2,
  output logic                         q_ovf
);
  localparam int W = DATA_WIDTH;
  typedef enum logic [2:0] {S_IDLE, S_P0, S_P1, S_P2, S_SUM, S_OUT} state_t;
  state_t state;
  logic [1:0] op;
  logic [W-1:0] an, ad, bn, bd, p0, p1, p2;
  logic ovf;
  logic [W-1:0] mx, my;
  logic [2*W-1:0] prod;
  logic mov;
  logic [W-1:0] sres;
  logic sov;

  always_comb begin
    unique case (state)
      S_P0:    begin mx = an; my = bd; end
      S_P1:    begin mx = ad; my = bn; end
      default: begin mx = ad; my = bd; end
    endcase
    // signed W x W multiply, full 2W-bit product
    prod = $signed(mx) * $signed(my);
    // exact product fits when upper bits are sign extension
    mov = (prod[2*W-1:W-1] != {(W+1){1'b0}}) && (prod[2*W-1:W-1] != {(W+1){1'b1}});
    if (op == OP_ADD) begin
      sres = p0 + p1;
      sov = (p0[W-1] == p1[W-1]) && (sres[W-1] != p0[W-1]);
    end else begin
      sres = p0 - p1;
      sov = (p0[W-1] != p1[W-1]) && (sres[W-1] != p0[W-1]);
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      q_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          op <= in_op; an <= in_an; ad <= in_ad; bn <= in_bn; bd <= in_bd;
          ovf <= 1'b0;
          state <= (in_op == OP_EQ) ? S_OUT : S_P0;
        end
        S_P0: begin p0 <= prod[W-1:0]; ovf <= ovf | mov; state <= S_P1; end
        S_P1: begin
          p1 <= prod[W-1:0]; ovf <= ovf | mov;
          state <= (op == OP_DIV) ? S_OUT : S_P2;
        end
        S_P2: begin p2 <= prod[W-1:0]; ovf <= ovf | mov; state <= S_SUM; end
        S_SUM: begin p0 <= sres; p1 <= p2; ovf <= ovf | sov; state <= S_OUT; end
        S_OUT: if (!q_valid || q_ready) begin
          q_valid <= 1'b1;
          // ovf stays clear for equality tests
          q_op <= op; q_ovf <= ovf;
          if (op == OP_EQ) begin
            q_n1 <= an; q_d1 <= ad; q_n2 <= bn; q_d2 <= bd;
          end else begin
            q_n1 <= p0; q_d1 <= p1; q_n2 <= '0; q_d2 <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (q_valid && q_ready && !(state == S_OUT)) q_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rar_reduce.sv
// rar_reduce: reduces one fraction by its gcd with a bit-serial divider.
// Depends on rar_pkg. One quotient bit per cycle.
`default_nettype none
module rar_reduce import rar_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] num,
  input  wire logic [DATA_WIDTH-1:0] den,
  output logic                       done,
  output logic [DATA_WIDTH-1:0]      rn,
  output logic [DATA_WIDTH-1:0]      rd
);
  localparam int W = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);
  typedef enum logic [2:0] {S_IDLE, S_GCD, S_DN, S_DD, S_DONE} state_t;
  state_t state;
  logic nneg, dneg;
  logic [W-1:0] mn, md, gx, gy;
  // divider: dividend shifting into remainder
  logic [W-1:0] dvd, dvs, rem, quo;
  logic [CW-1:0] cnt;
  logic [W:0] trial;
  logic [W-1:0] rem_sh;

  always_comb begin
    rem_sh = {rem[W-2:0], dvd[W-1]};
    trial = {rem[W-1], rem_sh} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          nneg <= num[W-1]; dneg <= den[W-1];
          mn <= num[W-1] ? -num : num;
          md <= den[W-1] ? -den : den;
          if (den == '0) begin
            rn <= (num == '0) ? '0 : (num[W-1] ? '1 : W'(1));
            rd <= '0;
            state <= S_DONE;
          end else if (num == den) begin
            rn <= W'(1); rd <= W'(1); state <= S_DONE;
          end else begin
            gx <= num[W-1] ? -num : num;
            gy <= den[W-1] ? -den : den;
            // no division in progress: forces a fresh remainder step
            dvs <= '0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // remainder step: gx % gy by serial division, then swap
          if (gy == '0) begin
            dvd <= mn; dvs <= gx; rem <= '0; cnt <= CW'(W);
            state <= S_DN;
          end else if (cnt == '0 && rem == '0 && dvs != gy) begin
            dvd <= gx; dvs <= gy; rem <= '0; cnt <= CW'(W);
          end else if (cnt != '0 && dvs == gy) begin
            dvd <= {dvd[W-2:0], 1'b0};
            rem <= trial[W] ? rem_sh : trial[W-1:0];
            cnt <= cnt - 1'b1;
          end else if (cnt == '0 && dvs == gy) begin
            gx <= gy; gy <= rem; dvs <= '0;
          end else begin
            dvd <= gx; dvs <= gy; rem <= '0; cnt <= CW'(W);
          end
        end
        S_DN, S_DD: begin
          if (cnt != '0) begin
            dvd <= {dvd[W-2:0], 1'b0};
            rem <= trial[W] ? rem_sh : trial[W-1:0];
            quo <= {quo[W-2:0], ~trial[W]};
            cnt <= cnt - 1'b1;
          end else if (state == S_DN) begin
            rn <= nneg ? -quo : quo;
            dvd <= md; rem <= '0; cnt <= CW'(W);
            state <= S_DD;
          end else begin
            rd <= dneg ? -quo : quo;
            state <= S_DONE;
          end
        end
        S_DONE: begin done <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rar_back.sv
// rar_back: takes queued items, reduces one or two fractions, drives results.
// Depends on rar_pkg and rar_reduce.
`default_nettype none
module rar_back import rar_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire logic [1:0]            q_op,
  input  wire logic [DATA_WIDTH-1:0] q_n1,
  input  wire logic [DATA_WIDTH-1:0] q_d1,
  input  wire logic [DATA_WIDTH-1:0] q_n2,
  input  wire logic [DATA_WIDTH-1:0] q_d2,
  input  wire logic                  q_ovf,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DATA_WIDTH-1:0]      out_num,
  output logic [DATA_WIDTH-1:0]      out_den,
  output logic                       out_eq,
  output logic                       out_ovf
);
  localparam int W = DATA_WIDTH;
  typedef enum logic [2:0] {S_IDLE, S_R1, S_R2, S_OUT} state_t;
  state_t state;
  logic [1:0] op;
  logic ovf;
  logic [W-1:0] n2, d2, r1n, r1d;
  logic rstart, rdone;
  logic [W-1:0] rin_n, rin_d, rn, rd;

  assign q_ready = (state == S_IDLE);
  assign rstart = (state == S_IDLE && q_valid) || (state == S_R1 && rdone && op == OP_EQ);
  assign rin_n = (state == S_IDLE) ? q_n1 : n2;
  assign rin_d = (state == S_IDLE) ? q_d1 : d2;

  rar_reduce #(.DATA_WIDTH(DATA_WIDTH)) u_red (
    .clk(clk), .rst(rst), .start(rstart), .num(rin_n), .den(rin_d),
    .done(rdone), .rn(rn), .rd(rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          op <= q_op; ovf <= q_ovf; n2 <= q_n2; d2 <= q_d2;
          state <= S_R1;
        end
        S_R1: if (rdone) begin
          r1n <= rn; r1d <= rd;
          state <= (op == OP_EQ) ? S_R2 : S_OUT;
        end
        S_R2: if (rdone) state <= S_OUT;
        S_OUT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          if (op == OP_EQ) begin
            out_num <= '0; out_den <= '0; out_ovf <= 1'b0;
            out_eq <= (r1n == rn) && (r1d == rd);
          end else begin
            out_num <= r1n; out_den <= r1d; out_ovf <= ovf; out_eq <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
    end
  end

  a_eq_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_eq |-> out_num == '0 && out_den == '0 && !out_ovf)
    else $error("equality result carries fraction");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    rstart |-> state == S_IDLE || state == S_R1)
    else $error("reducer started out of order");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_num))
    else $error("stalled result changed");
endmodule
`default_nettype wire

FILE: hw/rtl/rational_arith_reduce.sv
// rational_arith_reduce: top level, front (products) and back (gcd reduce).
// Depends on rar_pkg, rar_front, rar_back.
// One item in flight in each part. Front: after accept, equality tests go
// straight out; divide forms two products, add/sub three and a sum, on a
// shared multiplier. Back: each fraction reduced takes k Euclid remainder
// steps on a bit-serial divider, then two divisions (num and den by the gcd);
// a zero denominator or equal num and den skips these steps. Equality tests
// reduce two fractions.
// The front takes the next item while the back reduces, through a one-item
// register; results hold in an output register until taken.
`default_nettype none
module rational_arith_reduce import rar_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // tdata: req_type[1:0], a_num, a_den, b_num, b_den (low to high), zero pad
  input  wire logic [((2+4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // tdata: res_num, res_den, is_equal, overflow (low to high), zero pad
  output logic [((2+2*DATA_WIDTH+7)/8)*8-1:0] m_tdata
);
  localparam int W = DATA_WIDTH;
  localparam int OW = ((2 + 2 * DATA_WIDTH + 7) / 8) * 8;
  logic qv, qr, qovf;
  logic [1:0] qop;
  logic [W-1:0] qn1, qd1, qn2, qd2, on, od;
  logic oeq, oov;

  rar_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_op(s_tdata[1:0]), .in_an(s_tdata[2 +: W]), .in_ad(s_tdata[2+W +: W]),
    .in_bn(s_tdata[2+2*W +: W]), .in_bd(s_tdata[2+3*W +: W]),
    .q_valid(qv), .q_ready(qr), .q_op(qop), .q_n1(qn1), .q_d1(qd1),
    .q_n2(qn2), .q_d2(qd2), .q_ovf(qovf)
  );

  rar_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(qv), .q_ready(qr), .q_op(qop),
    .q_n1(qn1), .q_d1(qd1), .q_n2(qn2), .q_d2(qd2), .q_ovf(qovf),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_num(on), .out_den(od),
    .out_eq(oeq), .out_ovf(oov)
  );

  assign m_tdata = OW'({oov, oeq, od, on});
endmodule
`default_nettype wire
